// ===== hw/rtl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants for poly_from_roots
// Cell operation codes and the control bundle broadcast along the cell chain.
// ----------------------------------------------------------------------------
package pfr_pkg;

    // coefficient and root width (signed fixed point)
    localparam int DATA_W = 32;

    // operation applied by every cell in the same cycle
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD   = 2'd0;  // keep value
    localparam t_cell_op OP_ABSORB = 2'd1;  // c[j] <= c[j] - round(r * c[j-1])
    localparam t_cell_op OP_SHIFT  = 2'd2;  // c[j] <= c[j+1] (emission)
    localparam t_cell_op OP_CLEAR  = 2'd3;  // reload the initial value

    // control broadcast to every cell
    typedef struct packed {
        t_cell_op                   op;
        logic signed [DATA_W-1:0]   root;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/pfr_cell.sv =====
// ----------------------------------------------------------------------------
// pfr_cell: one coefficient cell of the root expansion chain
// Holds one coefficient; absorbs a root with a rounded, saturating
// multiply-subtract against its lower neighbor, or shifts toward the head.
// ----------------------------------------------------------------------------
module pfr_cell #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pfr_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [pfr_pkg::DATA_W-1:0]    i_init,   // value after reset/clear
    input  logic signed [pfr_pkg::DATA_W-1:0]    i_prev,   // c[j-1] from neighbor
    input  logic signed [pfr_pkg::DATA_W-1:0]    i_next,   // c[j+1] from neighbor
    output logic signed [pfr_pkg::DATA_W-1:0]    o_coeff,
    output logic                                 o_sat
);

    localparam int PW = 2 * pfr_pkg::DATA_W;
    localparam logic signed [PW-1:0] HALF  = (PW'(1) << FRAC_BITS) >>> 1;
    localparam logic signed [PW-1:0] SMAX  = PW'({1'b0, {(pfr_pkg::DATA_W-1){1'b1}}});
    localparam logic signed [PW-1:0] SMIN  = -SMAX - PW'(1);

    logic signed [pfr_pkg::DATA_W-1:0] r_coeff;
    logic signed [pfr_pkg::DATA_W-1:0] n_coeff;
    logic signed [PW-1:0]              w_prod;
    logic signed [PW-1:0]              w_round;
    logic signed [PW-1:0]              w_diff;
    logic signed [pfr_pkg::DATA_W-1:0] w_absorb;

    // rounded product, difference and saturation
    always_comb begin
        w_prod  = PW'(i_ctrl.root) * PW'(i_prev);
        w_round = (w_prod + HALF) >>> FRAC_BITS;
        w_diff  = PW'(r_coeff) - w_round;
        o_sat   = 1'b0;
        if (w_diff > SMAX) begin
            w_absorb = SMAX[pfr_pkg::DATA_W-1:0];
            o_sat    = (i_ctrl.op == pfr_pkg::OP_ABSORB);
        end else if (w_diff < SMIN) begin
            w_absorb = SMIN[pfr_pkg::DATA_W-1:0];
            o_sat    = (i_ctrl.op == pfr_pkg::OP_ABSORB);
        end else begin
            w_absorb = w_diff[pfr_pkg::DATA_W-1:0];
        end
    end

    // next value by operation
    always_comb begin
        unique case (i_ctrl.op)
            pfr_pkg::OP_HOLD:   n_coeff = r_coeff;
            pfr_pkg::OP_ABSORB: n_coeff = w_absorb;
            pfr_pkg::OP_SHIFT:  n_coeff = i_next;
            pfr_pkg::OP_CLEAR:  n_coeff = i_init;
            default:            n_coeff = r_coeff;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= i_init;
        end else begin
            r_coeff <= n_coeff;
        end
    end

    assign o_coeff = r_coeff;

endmodule

// ===== hw/rtl/poly_from_roots.sv =====
// ----------------------------------------------------------------------------
// poly_from_roots: expand real roots into monic polynomial coefficients
// Chain of MAX_ROOTS+1 coefficient cells driven by a small run controller.
// ----------------------------------------------------------------------------
// Roots enter one per transaction on the slave stream as signed fixed point
// with FRAC_BITS fraction bits. Each accepted root is absorbed by all cells
// together: every cell does its own multiply-subtract against its neighbor in
// parallel, so roots may stream at one per clock outside emission. On the
// root marked tlast the block stops taking input and emits count+1
// coefficients on the master stream, leading one first, one per cycle while
// tready is high (the chain shifts toward cell 0, which drives tdata); tlast
// marks the constant term and tuser carries the overflow flag on every
// coefficient of the run. Roots beyond MAX_ROOTS are dropped and flag
// overflow, as does any saturation of a coefficient.
// ----------------------------------------------------------------------------
module poly_from_roots #(
    parameter int MAX_ROOTS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: roots
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] root_value
    input  logic        i_s_tlast,    // root_is_last
    // master stream: coefficients
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [31:0] coeff_value
    output logic        o_m_tlast,    // coeff_last
    output logic        o_m_tuser     // [0] overflow_flag
);

    localparam int CW    = $clog2(MAX_ROOTS + 1);
    localparam int NCELL = MAX_ROOTS + 1;
    localparam logic signed [pfr_pkg::DATA_W-1:0] ONE =
        pfr_pkg::DATA_W'(1) << FRAC_BITS;

    localparam logic ST_ABSORB = 1'b0;
    localparam logic ST_EMIT   = 1'b1;

    logic          r_state,  n_state;
    logic [CW-1:0] r_count,  n_count;
    logic [CW-1:0] r_left,   n_left;
    logic          r_sticky, n_sticky;

    logic                w_accept;
    logic                w_room;
    logic                w_any_sat;
    pfr_pkg::t_cell_ctrl w_ctrl;

    logic signed [pfr_pkg::DATA_W-1:0] w_coeff [NCELL];
    logic signed [pfr_pkg::DATA_W-1:0] w_prev  [NCELL];
    logic signed [pfr_pkg::DATA_W-1:0] w_next  [NCELL];
    logic signed [pfr_pkg::DATA_W-1:0] w_init  [NCELL];
    logic [NCELL-1:0]                  w_sat;

    // handshakes
    assign o_s_tready = (r_state == ST_ABSORB);
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_room     = (r_count < CW'(MAX_ROOTS));
    assign w_any_sat  = |w_sat;

    // run controller
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_sticky    = r_sticky;
        w_ctrl.op   = pfr_pkg::OP_HOLD;
        w_ctrl.root = $signed(i_s_tdata);
        unique case (r_state)
            ST_ABSORB: begin
                if (w_accept) begin
                    if (w_room) begin
                        w_ctrl.op = pfr_pkg::OP_ABSORB;
                        n_count   = r_count + CW'(1);
                        n_sticky  = r_sticky | w_any_sat;
                    end else begin
                        n_sticky  = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state = ST_EMIT;
                        n_left  = w_room ? r_count + CW'(1) : r_count;
                    end
                end
            end
            ST_EMIT: begin
                if (i_m_tready) begin
                    if (r_left == '0) begin
                        w_ctrl.op = pfr_pkg::OP_CLEAR;
                        n_state   = ST_ABSORB;
                        n_count   = '0;
                        n_sticky  = 1'b0;
                    end else begin
                        w_ctrl.op = pfr_pkg::OP_SHIFT;
                        n_left    = r_left - CW'(1);
                    end
                end
            end
            default: n_state = ST_ABSORB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ABSORB;
            r_count  <= '0;
            r_left   <= '0;
            r_sticky <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_sticky <= n_sticky;
        end
    end

    // cell chain: c[0] at the head drives the output
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_prev[j] = '0;
            assign w_init[j] = ONE;
        end else begin : g_body
            assign w_prev[j] = w_coeff[j-1];
            assign w_init[j] = '0;
        end
        if (j == NCELL - 1) begin : g_tail
            assign w_next[j] = '0;
        end else begin : g_link
            assign w_next[j] = w_coeff[j+1];
        end

        pfr_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_init  (w_init[j]),
            .i_prev  (w_prev[j]),
            .i_next  (w_next[j]),
            .o_coeff (w_coeff[j]),
            .o_sat   (w_sat[j])
        );
    end

    // output stream
    assign o_m_tvalid = (r_state == ST_EMIT);
    assign o_m_tdata  = w_coeff[0];
    assign o_m_tlast  = (r_state == ST_EMIT) && (r_left == '0);
    assign o_m_tuser  = r_sticky;

    // checks
    a_no_input_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input taken during emission");

    a_last_root_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tlast) |=> (o_m_tvalid && o_m_tdata == ONE))
        else $error("run did not start with leading coefficient");

    a_run_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=>
            (!o_m_tvalid && r_count == '0 && !r_sticky && w_coeff[0] == ONE))
        else $error("state not cleared after run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(MAX_ROOTS)) && (r_left <= r_count))
        else $error("root count out of range");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for poly_from_roots
// Feeds sets of fixed-point roots on the slave stream and compares every
// coefficient on the master stream against a cycle-free software expansion.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DATA_W    = pfr_pkg::DATA_W;
    localparam int MAX_ROOTS = 16;
    localparam int FRAC_BITS = 16;
    localparam int LIMIT     = 200000;
    localparam int IDLE_PCT  = 32;
    localparam int HOLD_LEN  = 300;

    // one root transaction; hold_for_drain makes the sender wait for all results
    typedef struct {
        logic [DATA_W-1:0] root;
        logic              last;
        bit                hold_for_drain;
    } t_root_txn;

    // one coefficient transaction
    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } t_coeff_txn;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata  = '0;   // [31:0] root_value
    logic              i_s_tlast  = 1'b0; // root_is_last
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;         // [31:0] coeff_value
    logic              o_m_tlast;         // coeff_last
    logic              o_m_tuser;         // [0] overflow_flag

    poly_from_roots #(
        .MAX_ROOTS (MAX_ROOTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_root_txn  root_q[$];
    t_coeff_txn coeff_expect_q[$];
    int         src_idle_pct  = IDLE_PCT;
    int         sink_idle_pct = IDLE_PCT;
    bit         stall_req     = 1'b0;
    bit         stall_done    = 1'b0;
    int         n_roots       = 0;
    int         n_coeffs      = 0;
    int         n_errors      = 0;
    int         cyc_cnt       = 0;

    // ------------------------------------------------------------------------
    // Coefficient expansion: own copy of the store, count and sticky flag
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] coef_store [0:MAX_ROOTS];
    int                       root_cnt;
    bit                       sticky_ovf;

    function automatic void clear_store();
        for (int j = 0; j <= MAX_ROOTS; j++)
            coef_store[j] = '0;
        coef_store[0] = DATA_W'(1) << FRAC_BITS;
        root_cnt   = 0;
        sticky_ovf = 1'b0;
    endfunction

    // c[j] -= round(r * c[j-1]), top down so c[j-1] is still the old value
    function automatic void absorb_root(input logic signed [DATA_W-1:0] r);
        logic signed [63:0] prod;
        logic signed [63:0] diff;
        for (int j = root_cnt + 1; j >= 1; j--) begin
            prod = r * coef_store[j-1];
            if (FRAC_BITS > 0)
                prod = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            diff = coef_store[j] - prod;
            if (diff > 64'sh7FFF_FFFF) begin
                coef_store[j] = 32'sh7FFF_FFFF;
                sticky_ovf    = 1'b1;
            end else if (diff < -64'sh8000_0000) begin
                coef_store[j] = 32'sh8000_0000;
                sticky_ovf    = 1'b1;
            end else begin
                coef_store[j] = diff[DATA_W-1:0];
            end
        end
        root_cnt++;
    endfunction

    function automatic void expand_root(input t_root_txn txn);
        t_coeff_txn c;
        if (root_cnt < MAX_ROOTS)
            absorb_root(txn.root);
        else
            sticky_ovf = 1'b1;
        if (txn.last) begin
            for (int k = 0; k <= root_cnt; k++) begin
                c.value = coef_store[k];
                c.last  = (k == root_cnt);
                c.ovf   = sticky_ovf;
                coeff_expect_q = {coeff_expect_q, c};
            end
            clear_store();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Root driver
    // ------------------------------------------------------------------------
    t_root_txn cur_root;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            clear_store();
        end else begin
            if (i_s_tvalid && o_s_tready)
                expand_root(cur_root);
            if (!i_s_tvalid || o_s_tready) begin
                if (root_q.size() > 0 && $urandom_range(99) >= src_idle_pct &&
                    !(root_q[0].hold_for_drain && coeff_expect_q.size() > 0)) begin
                    cur_root = root_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= cur_root.root;
                    i_s_tlast  <= cur_root.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Coefficient monitor and back-pressure
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge i_clk) begin
        t_coeff_txn exp_c;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (coeff_expect_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected coefficient %h last %b ovf %b",
                                 o_m_tdata, o_m_tlast, o_m_tuser);
                end else begin
                    exp_c = coeff_expect_q.pop_front();
                    if (o_m_tdata !== exp_c.value || o_m_tlast !== exp_c.last ||
                        o_m_tuser !== exp_c.ovf) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("coeff %0d: exp %h/%b/%b got %h/%b/%b",
                                     n_coeffs, exp_c.value, exp_c.last, exp_c.ovf,
                                     o_m_tdata, o_m_tlast, o_m_tuser);
                    end
                end
                n_coeffs++;
            end
            // one long hold-off on request, otherwise random idling
            if (stall_req && !stall_done) begin
                hold_left  = HOLD_LEN;
                stall_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void push_root(input logic [DATA_W-1:0] r, input logic last,
                                      input bit drain);
        t_root_txn t;
        t.root           = r;
        t.last           = last;
        t.hold_for_drain = drain;
        root_q = {root_q, t};
        n_roots++;
    endfunction

    // mostly small roots so long sets stay in range, some full range and corners
    function automatic logic [DATA_W-1:0] pick_root();
        int unsigned sel;
        int          v;
        sel = $urandom_range(99);
        if (sel < 70) begin
            v = int'($urandom_range(393216)) - 196608;
            return v;
        end else if (sel < 85) begin
            return $urandom();
        end
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0001_0000;
            4:       return 32'hFFFF_0000;
            default: return 32'h0000_8000;
        endcase
    endfunction

    function automatic void push_random_set(input bit drain);
        int unsigned sel;
        int          len;
        sel = $urandom_range(99);
        if (sel < 75)
            len = $urandom_range(6, 1);
        else if (sel < 90)
            len = $urandom_range(MAX_ROOTS, 7);
        else
            len = $urandom_range(MAX_ROOTS + 4, MAX_ROOTS + 1);
        for (int i = 0; i < len; i++)
            push_root(pick_root(), i == len - 1, drain && i == 0);
    endfunction

    task automatic wait_sent();
        while (root_q.size() > 0 || i_s_tvalid)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero root, both extremes, x^2 - 1
        push_root(32'h0000_0000, 1'b1, 1'b0);
        push_root(32'h7FFF_FFFF, 1'b1, 1'b0);
        push_root(32'h8000_0000, 1'b1, 1'b0);
        push_root(32'h0001_0000, 1'b0, 1'b0);
        push_root(32'hFFFF_0000, 1'b1, 1'b0);
        // rounding tie on a negative product
        push_root(32'h0000_8000, 1'b0, 1'b0);
        push_root(32'h0000_0001, 1'b1, 1'b0);
        // a full store, then a last root that no longer fits
        for (int i = 0; i < MAX_ROOTS; i++)
            push_root((i % 2) ? 32'h0001_0000 : 32'hFFFF_8000, 1'b0, 1'b0);
        push_root(32'h0002_0000, 1'b1, 1'b0);

        // random part with idling on both sides
        while (n_roots < 110)
            push_random_set($urandom_range(99) < 5);
        wait_sent();

        // receiver holds off while the sender keeps offering
        stall_req = 1'b1;
        while (n_roots < 150)
            push_random_set(1'b0);
        wait_sent();

        // no idling at all, starting from a fully drained block
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        push_random_set(1'b1);
        while (n_roots < 200)
            push_random_set(1'b0);
        wait_sent();

        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
        while (n_roots < 260)
            push_random_set($urandom_range(99) < 5);
        wait_sent();

        while (coeff_expect_q.size() > 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (n_errors == 0 && coeff_expect_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
